// ----- hdl/trace_level_of_detail_merger_assert.svh -----
// assertion macros for the trace level-of-detail merger
// expects clk and arst_n in the scope of each use
`ifndef TRACE_LEVEL_OF_DETAIL_MERGER_ASSERT_SVH
`define TRACE_LEVEL_OF_DETAIL_MERGER_ASSERT_SVH

// same-cycle implication
`define TLDM_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tldm assertion failed");

// next-cycle implication
`define TLDM_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tldm assertion failed");

`endif

// ----- hdl/tldm_pkg.sv -----
// shared constants, payload structs and state type of the trace lod merger
// no dependencies
package tldm_pkg;

	localparam int MAX_DEPTHS = 64;
	localparam int LEVELS     = 9;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int DEP_W      = (MAX_DEPTHS > 1) ? $clog2(MAX_DEPTHS) : 1;
	localparam int ADDR_W     = $clog2(MAX_DEPTHS * LEVELS);
	localparam int NUM_W      = 41;
	localparam int CNT_W      = $clog2(NUM_W);
	localparam int WIDTH_W    = 16;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1920;

	// base cycles of the level below, times the length pixel count
	localparam logic [NUM_W-1:0] LEN_NUMER [9] = '{
		41'd0,
		41'd10000,
		41'd2000000,
		41'd300000000,
		41'd3000000000,
		41'd6000000000,
		41'd60000000000,
		41'd200000000000,
		41'd2000000000000
	};

	typedef struct packed {
		logic [63:0] trace_start;
		logic [63:0] trace_end;
		logic [5:0]  trace_depth;
		logic [31:0] trace_index;
	} trace_t;

	typedef struct packed {
		logic [3:0]  detail_level;
		logic [63:0] span_start;
		logic [63:0] span_end;
		logic [31:0] span_index;
		logic [5:0]  span_depth;
		logic        span_merged;
		logic        last_result;
	} span_t;

	typedef struct packed {
		logic [63:0] sp_start;
		logic [63:0] sp_end;
		logic [31:0] sp_index;
		logic        sp_merged;
	} ent_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   numer;
		logic [WIDTH_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_THR_START,
		ST_THR_WAIT,
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

// ----- hdl/tldm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module tldm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/tldm_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on tldm_pkg
module tldm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tldm_pkg::div_req_t req,
	output tldm_pkg::div_rsp_t rsp
);
	import tldm_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   quo_q;
	logic [WIDTH_W-1:0] den_q;
	logic [WIDTH_W-1:0] rem_q;
	logic [WIDTH_W:0]   sh;
	logic               ge;

	assign sh = {rem_q, num_q[NUM_W-1]};
	assign ge = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.numer;
			den_q <= req.denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? WIDTH_W'(sh - {1'b0, den_q}) : sh[WIDTH_W-1:0];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- hdl/trace_level_of_detail_merger.sv -----
// top level of the trace level-of-detail span merger
// depends on tldm_pkg, tldm_ram, tldm_div and the assertion macro header
//
// usage:
// - trace channel (trace_valid/trace_ready/trace) takes one timed trace per
//   transaction; span channel (span_valid/span_ready/span) gives the closed
//   spans it causes, highest detail level first, last_result on the final one
// - cfg channel (cfg_valid/cfg_ready/cfg_data) writes screen_width; it is
//   taken only while no trace is in work
// - each trace makes one read-modify-write of the open-span ram per level,
//   levels 8 down to 0, through a two-stage read/compare pipe: a trace
//   occupies the block until its level 0 write-back, and longer while the
//   span receiver stalls with a result pending
// - up to 9 spans per trace; a trace whose depth was never seen gives none
// - the span output register lets the next trace be taken while the last
//   span of the previous one still waits for span_ready
// - after reset and after every cfg write the level thresholds are rebuilt
//   by a bit-serial divider, and trace_ready and cfg_ready stay low until
//   the rebuild is through
// - reset marks every depth row empty, so no ram clearing pass is needed
`include "trace_level_of_detail_merger_assert.svh"

module trace_level_of_detail_merger (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         trace_valid,
	output logic                         trace_ready,
	input  tldm_pkg::trace_t             trace,
	output logic                         span_valid,
	input  logic                         span_ready,
	output tldm_pkg::span_t              span,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tldm_pkg::WIDTH_W-1:0] cfg_data
);
	import tldm_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [WIDTH_W-1:0] width_q;
	logic [LVL_W-1:0]   thr_lvl_q;
	logic [NUM_W-1:0]   thr_q [LEVELS];
	logic               row_vld_q [MAX_DEPTHS];

	trace_t             trace_q;
	logic [63:0]        delta_q;
	logic [ADDR_W-1:0]  base_q;
	logic               hit_q;
	logic               rd_more_q;
	logic [LVL_W-1:0]   rd_lvl_q;

	logic               vld_s1_q;
	logic [LVL_W-1:0]   lvl_s1_q;
	logic [ADDR_W-1:0]  addr_s1_q;

	logic               vld_s2_q;
	logic [LVL_W-1:0]   lvl_s2_q;
	logic [ADDR_W-1:0]  addr_s2_q;
	ent_t               ent_s2_q;
	logic [63:0]        plen_s2_q;
	logic [63:0]        gap_s2_q;
	logic [NUM_W-1:0]   thr_s2_q;

	logic               span_valid_q;
	span_t              span_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               trace_acc;
	logic               cfg_acc;
	logic               depth_ok;
	logic [DEP_W-1:0]   dep_idx;
	logic               thr_last;
	logic               stall;
	logic               adv;
	logic               re;
	logic [ADDR_W-1:0]  raddr;
	ent_t               ram_rd;
	logic [$bits(ent_t)-1:0] ram_rdata;
	ent_t               wr_ent;
	logic               we;
	logic [63:0]        plen_s1;
	logic [64:0]        dif_a;
	logic [63:0]        dif_b;
	logic [63:0]        gap_s1;
	logic [NUM_W-1:0]   thr_s1;
	logic [63:0]        len_thr;
	logic [63:0]        gap_thr;
	logic               merge_s2;
	logic               emit_s2;

	// handshakes
	assign trace_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready   = (state_q == ST_IDLE);
	assign trace_acc   = trace_valid && trace_ready;
	assign cfg_acc     = cfg_valid && cfg_ready;
	assign depth_ok    = (32'(trace.trace_depth) < MAX_DEPTHS);
	assign dep_idx     = DEP_W'(trace.trace_depth);
	assign thr_last    = (thr_lvl_q == LVL_W'(LEVELS - 1));

	// threshold divider
	assign div_req.start = (state_q == ST_THR_START);
	assign div_req.numer = LEN_NUMER[thr_lvl_q];
	assign div_req.denom = (width_q == '0) ? WIDTH_W'(1) : width_q;

	tldm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// pipe control
	assign stall = vld_s2_q && emit_s2 && span_valid_q && !span_ready;
	assign adv   = !stall;
	assign re    = (state_q == ST_RUN) && rd_more_q && adv;
	assign raddr = base_q + ADDR_W'(rd_lvl_q);

	// stage 1: ram data against the trace
	assign ram_rd  = ram_rdata;
	assign plen_s1 = ram_rd.sp_end - ram_rd.sp_start;
	assign dif_a   = {1'b0, trace_q.trace_start} - {1'b0, ram_rd.sp_end};
	assign dif_b   = ram_rd.sp_end - trace_q.trace_start;
	assign gap_s1  = dif_a[64] ? dif_b : dif_a[63:0];
	assign thr_s1  = (lvl_s1_q == '0) ? '0 : thr_q[lvl_s1_q];

	// stage 2: merge decision and write-back
	assign len_thr  = 64'(thr_s2_q);
	assign gap_thr  = 64'(thr_s2_q >> 1);
	assign merge_s2 = hit_q && (plen_s2_q < len_thr) && (delta_q < len_thr)
		&& (gap_s2_q < gap_thr);
	assign emit_s2  = hit_q && !merge_s2;
	assign we       = vld_s2_q && adv;

	always_comb begin
		if (merge_s2) begin
			wr_ent.sp_start  = ent_s2_q.sp_start;
			wr_ent.sp_index  = ent_s2_q.sp_index;
			wr_ent.sp_merged = 1'b1;
		end else begin
			wr_ent.sp_start  = trace_q.trace_start;
			wr_ent.sp_index  = trace_q.trace_index;
			wr_ent.sp_merged = 1'b0;
		end
		wr_ent.sp_end = trace_q.trace_end;
	end

	tldm_ram #(
		.WIDTH ($bits(ent_t)),
		.DEPTH (MAX_DEPTHS * LEVELS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s2_q),
		.wdata (wr_ent),
		.re    (re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_THR_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_THR_START: begin
				state_d = ST_THR_WAIT;
			end
			ST_THR_WAIT: begin
				if (div_rsp.done) begin
					state_d = thr_last ? ST_IDLE : ST_THR_START;
				end
			end
			ST_IDLE: begin
				if (cfg_acc) begin
					state_d = ST_THR_START;
				end else if (trace_acc && depth_ok) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (adv && vld_s2_q && (lvl_s2_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WIDTH_RESET;
			thr_lvl_q    <= LVL_W'(1);
			rd_more_q    <= 1'b0;
			vld_s1_q     <= 1'b0;
			vld_s2_q     <= 1'b0;
			span_valid_q <= 1'b0;
			for (int i = 0; i < MAX_DEPTHS; i++) begin
				row_vld_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_acc) begin
				width_q   <= cfg_data;
				thr_lvl_q <= LVL_W'(1);
			end
			if ((state_q == ST_THR_WAIT) && div_rsp.done && !thr_last) begin
				thr_lvl_q <= thr_lvl_q + 1'b1;
			end
			if (trace_acc && depth_ok) begin
				row_vld_q[dep_idx] <= 1'b1;
				rd_more_q          <= 1'b1;
			end
			if (re) begin
				rd_more_q <= (rd_lvl_q != '0);
			end
			if (adv) begin
				vld_s1_q <= re;
				vld_s2_q <= vld_s1_q;
			end
			if (adv && vld_s2_q && emit_s2) begin
				span_valid_q <= 1'b1;
			end else if (span_ready) begin
				span_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_THR_WAIT) && div_rsp.done) begin
			thr_q[thr_lvl_q] <= div_rsp.quo;
		end
		if (trace_acc) begin
			trace_q  <= trace;
			delta_q  <= trace.trace_end - trace.trace_start;
			base_q   <= ADDR_W'(trace.trace_depth) * ADDR_W'(LEVELS);
			hit_q    <= row_vld_q[dep_idx];
			rd_lvl_q <= LVL_W'(LEVELS - 1);
		end
		if (re) begin
			rd_lvl_q  <= rd_lvl_q - 1'b1;
			lvl_s1_q  <= rd_lvl_q;
			addr_s1_q <= raddr;
		end
		if (adv && vld_s1_q) begin
			lvl_s2_q  <= lvl_s1_q;
			addr_s2_q <= addr_s1_q;
			ent_s2_q  <= ram_rd;
			plen_s2_q <= plen_s1;
			gap_s2_q  <= gap_s1;
			thr_s2_q  <= thr_s1;
		end
		if (adv && vld_s2_q && emit_s2) begin
			span_q.detail_level <= 4'(lvl_s2_q);
			span_q.span_start   <= ent_s2_q.sp_start;
			span_q.span_end     <= ent_s2_q.sp_end;
			span_q.span_index   <= ent_s2_q.sp_index;
			span_q.span_depth   <= trace_q.trace_depth;
			span_q.span_merged  <= ent_s2_q.sp_merged;
			span_q.last_result  <= (lvl_s2_q == '0);
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

	`TLDM_ASSERT_IMP(a_idle_pipe_empty, trace_ready, !vld_s1_q && !vld_s2_q)
	`TLDM_ASSERT_IMP(a_ram_write_in_run, we, state_q == ST_RUN)
	`TLDM_ASSERT_NXT(a_stall_holds_s2, stall, vld_s2_q && $stable(lvl_s2_q))
	`TLDM_ASSERT_NXT(a_level_order, adv && vld_s2_q && (lvl_s2_q != '0),
		vld_s2_q && (lvl_s2_q == LVL_W'($past(lvl_s2_q) - 1'b1)))
	`TLDM_ASSERT_IMP(a_div_done_waited, div_rsp.done, state_q == ST_THR_WAIT)

endmodule

// ----- tb/trace_level_of_detail_merger_tb.sv -----
// testbench for trace_level_of_detail_merger: a directed table of traces, then random
// trace sequences under five screen widths, each span transaction checked against table-typed or local model spans
// depends on tldm_pkg and the merger rtl
module trace_level_of_detail_merger_tb;
	import tldm_pkg::*;

	typedef struct packed {
		logic [5:0]         dep;
		logic [63:0]        st;
		logic [63:0]        en;
		logic [31:0]        ix;
		logic signed [7:0]  n_typed;
		logic [63:0]        x_st;
		logic [63:0]        x_en;
		logic [31:0]        x_ix;
	} dir_row_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_TIGHT
	} rx_mode_t;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 30;
	localparam int SETTLE_CYCLES  = 24;
	localparam int RAND_PER_PHASE = 22;
	localparam int NUM_PHASES     = 5;
	localparam int DIR_ROWS       = 21;

	localparam logic [63:0] ALL1    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALT_A   = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] ALT_5   = 64'h5555_5555_5555_5555;
	localparam logic [63:0] Z64     = 64'd0;
	localparam logic [31:0] Z32     = 32'd0;
	localparam logic [31:0] IDX_MAX = 32'hFFFF_FFFE;
	localparam logic signed [7:0] BY_MODEL = -8'sd1;
	localparam logic signed [7:0] NONE     = 8'sd0;
	localparam logic signed [7:0] ALL_LVLS = 8'sd9;

	localparam logic [63:0] LEN_PX = 64'd10;
	localparam logic [63:0] GAP_PX = 64'd5;
	localparam logic [63:0] BASE_CYC [9] = '{
		64'd1000, 64'd200000, 64'd30000000, 64'd300000000, 64'd600000000,
		64'd6000000000, 64'd20000000000, 64'd200000000000, 64'd600000000000
	};

	// fresh depths give nothing; a far jump flushes every level
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{6'd0,  Z64, Z64, Z32, NONE, Z64, Z64, Z32},
		'{6'd0,  ALL1, ALL1, IDX_MAX, ALL_LVLS, Z64, Z64, Z32},
		'{6'd63, 64'd5, 64'd3, 32'd1, NONE, Z64, Z64, Z32},
		'{6'd63, 64'd3, 64'd4, 32'd2, BY_MODEL, Z64, Z64, Z32},
		'{6'd1,  64'd100, 64'd101, 32'd10, NONE, Z64, Z64, Z32},
		'{6'd1,  64'd102, 64'd103, 32'd11, BY_MODEL, Z64, Z64, Z32},
		'{6'd1,  64'd103, 64'd104, 32'd12, BY_MODEL, Z64, Z64, Z32},
		'{6'd1,  64'd106, 64'd107, 32'd13, BY_MODEL, Z64, Z64, Z32},
		'{6'd1,  64'd106, 64'd107, 32'd14, BY_MODEL, Z64, Z64, Z32},
		'{6'd1,  64'd108, 64'd113, 32'd15, BY_MODEL, Z64, Z64, Z32},
		'{6'd42, ALT_A, ALT_5, 32'hAAAA_AAAA, NONE, Z64, Z64, Z32},
		'{6'd21, ALT_5, ALT_A, 32'h5555_5555, NONE, Z64, Z64, Z32},
		'{6'd42, ALT_5, ALT_A, 32'd1, BY_MODEL, Z64, Z64, Z32},
		'{6'd21, ALT_A, ALT_5, 32'hAAAA_AAAA, BY_MODEL, Z64, Z64, Z32},
		'{6'd1,  64'd1000000000000, 64'd1000000000001, 32'd16, BY_MODEL, Z64, Z64, Z32},
		'{6'd63, 64'hFFFF_FFFF_FFFF_FFFE, ALL1, IDX_MAX, BY_MODEL, Z64, Z64, Z32},
		'{6'd0,  Z64, ALL1, Z32, BY_MODEL, Z64, Z64, Z32},
		'{6'd0,  ALL1, Z64, 32'd17, BY_MODEL, Z64, Z64, Z32},
		'{6'd2,  64'd500000000, 64'd500000100, 32'd20, NONE, Z64, Z64, Z32},
		'{6'd2,  64'd600000000, 64'd600000100, 32'd21, BY_MODEL, Z64, Z64, Z32},
		'{6'd0,  Z64, Z64, Z32, BY_MODEL, Z64, Z64, Z32}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               trace_valid;
	logic               trace_ready;
	trace_t             trace;
	logic               span_valid;
	logic               span_ready;
	span_t              span;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WIDTH_W-1:0] cfg_data;

	bit                 open_vld [MAX_DEPTHS][LEVELS];
	ent_t               open_ent [MAX_DEPTHS][LEVELS];
	logic [WIDTH_W-1:0] width_now;

	span_t              pending_spans[$];
	span_t              model_spans[$];
	span_t              typed_spans[$];
	logic [63:0]        tail_end [MAX_DEPTHS];
	logic [31:0]        next_index = 32'd100;

	int                 traces_sent   = 0;
	int                 spans_checked = 0;
	int                 merged_seen   = 0;
	int                 widths_done   = 0;
	int                 errors        = 0;
	int                 burst_left    = 0;
	int                 cycle_count   = 0;
	bit                 hold_done     = 1'b0;

	trace_level_of_detail_merger DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.trace_valid (trace_valid),
		.trace_ready (trace_ready),
		.trace       (trace),
		.span_valid  (span_valid),
		.span_ready  (span_ready),
		.span        (span),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] level_limit(int lvl, logic [63:0] px);
		logic [63:0] w;
		w = (width_now == '0) ? 64'd1 : 64'(width_now);
		if (lvl == 0)
			return 64'd0;
		return (BASE_CYC[lvl-1] * px) / w;
	endfunction

	// walks levels high to low, folding the trace in or closing the open span
	function automatic void merge_trace(trace_t t);
		logic [63:0] t_len;
		logic [63:0] o_len;
		logic [63:0] gap;
		logic        fold;
		int          d;
		span_t       s;
		model_spans.delete();
		d = int'(t.trace_depth);
		t_len = t.trace_end - t.trace_start;
		for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
			fold = 1'b0;
			if (open_vld[d][lvl]) begin
				o_len = open_ent[d][lvl].sp_end - open_ent[d][lvl].sp_start;
				if (t.trace_start > open_ent[d][lvl].sp_end)
					gap = t.trace_start - open_ent[d][lvl].sp_end;
				else
					gap = open_ent[d][lvl].sp_end - t.trace_start;
				fold = (o_len < level_limit(lvl, LEN_PX)) && (t_len < level_limit(lvl, LEN_PX))
					&& (gap < level_limit(lvl, GAP_PX));
			end
			if (fold) begin
				open_ent[d][lvl].sp_merged = 1'b1;
			end else begin
				if (open_vld[d][lvl]) begin
					s.detail_level = 4'(lvl);
					s.span_start   = open_ent[d][lvl].sp_start;
					s.span_end     = open_ent[d][lvl].sp_end;
					s.span_index   = open_ent[d][lvl].sp_index;
					s.span_depth   = t.trace_depth;
					s.span_merged  = open_ent[d][lvl].sp_merged;
					s.last_result  = 1'b0;
					model_spans.insert(model_spans.size(), s);
				end
				open_vld[d][lvl] = 1'b1;
				open_ent[d][lvl].sp_start  = t.trace_start;
				open_ent[d][lvl].sp_index  = t.trace_index;
				open_ent[d][lvl].sp_merged = 1'b0;
			end
			open_ent[d][lvl].sp_end = t.trace_end;
		end
		if (model_spans.size() != 0) begin
			s = model_spans.pop_back();
			s.last_result = 1'b1;
			model_spans.insert(model_spans.size(), s);
		end
	endfunction

	// mostly chained traces per depth with scaled lengths and gaps, some raw noise
	function automatic trace_t random_trace();
		trace_t      t;
		logic [63:0] dur;
		logic [63:0] gapv;
		if ($urandom_range(0, 4) != 0)
			t.trace_depth = 6'($urandom_range(0, 3));
		else
			t.trace_depth = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 99) < 85) begin
			dur  = rand64() >> (63 - $urandom_range(0, 43));
			gapv = rand64() >> (63 - $urandom_range(0, 41));
			if ($urandom_range(0, 3) == 0)
				t.trace_start = tail_end[t.trace_depth] - gapv;
			else
				t.trace_start = tail_end[t.trace_depth] + gapv;
			t.trace_end = t.trace_start + dur;
		end else begin
			t.trace_start = rand64();
			t.trace_end   = rand64();
		end
		tail_end[t.trace_depth] = t.trace_end;
		if ($urandom_range(0, 9) == 0) begin
			t.trace_index = $urandom_range(0, IDX_MAX);
		end else begin
			t.trace_index = next_index;
			next_index = next_index + 32'd1;
		end
		return t;
	endfunction

	function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		return 1;
	endfunction

	task automatic send_trace(trace_t t, bit typed);
		trace_valid <= 1'b1;
		trace       <= t;
		do @(posedge clk); while (!trace_ready);
		traces_sent++;
		merge_trace(t);
		if (typed) begin
			foreach (typed_spans[i])
				pending_spans.insert(pending_spans.size(), typed_spans[i]);
		end else begin
			foreach (model_spans[i])
				pending_spans.insert(pending_spans.size(), model_spans[i]);
		end
	endtask

	task automatic sender_pause();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			trace_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(logic [WIDTH_W-1:0] w);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		width_now = w;
		widths_done++;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				sender_pause();
			send_trace(random_trace(), 1'b0);
		end
		trace_valid <= 1'b0;
	endtask

	// span receiver: a changing ready pattern, broken by one long hold-off once HOLD_AFTER traces have been sent
	initial begin
		rx_mode_t rx_mode;
		int       rx_cycle;
		rx_mode    = RX_OPEN;
		rx_cycle   = 0;
		span_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && traces_sent >= HOLD_AFTER) begin
				span_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (rx_cycle % 64 == 0)
					rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_cycle++;
				case (rx_mode)
					RX_OPEN:  span_ready <= 1'b1;
					RX_COIN:  span_ready <= ($urandom_range(0, 1) == 1);
					default:  span_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		span_t want;
		if (arst_n && span_valid && span_ready) begin
			if (pending_spans.size() == 0) begin
				$display("%0t: span transaction with none expected, got %p", $time, span);
				errors++;
			end else begin
				want = pending_spans.pop_front();
				errors += field_diff("detail_level", 64'(want.detail_level),
					64'(span.detail_level));
				errors += field_diff("span_start", want.span_start, span.span_start);
				errors += field_diff("span_end", want.span_end, span.span_end);
				errors += field_diff("span_index", 64'(want.span_index), 64'(span.span_index));
				errors += field_diff("span_depth", 64'(want.span_depth), 64'(span.span_depth));
				errors += field_diff("span_merged", 64'(want.span_merged),
					64'(span.span_merged));
				errors += field_diff("last_result", 64'(want.last_result),
					64'(span.last_result));
				spans_checked++;
				if (span.span_merged)
					merged_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d spans outstanding", $time,
				cycle_count, pending_spans.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		trace_t             t;
		span_t              s;
		dir_row_t           row;
		logic [WIDTH_W-1:0] phase_width [NUM_PHASES];
		arst_n      = 1'b0;
		trace_valid = 1'b0;
		trace       = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		width_now   = WIDTH_RESET;
		foreach (tail_end[i])
			tail_end[i] = 64'd0;
		phase_width[0] = 16'd1;
		phase_width[1] = 16'hFFFF;
		phase_width[2] = 16'd0;
		phase_width[3] = 16'($urandom_range(2, 65534));
		phase_width[4] = WIDTH_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TAB[i];
			t.trace_start = row.st;
			t.trace_end   = row.en;
			t.trace_depth = row.dep;
			t.trace_index = row.ix;
			typed_spans.delete();
			if (row.n_typed == ALL_LVLS) begin
				for (int l = LEVELS - 1; l >= 0; l--) begin
					s.detail_level = 4'(l);
					s.span_start   = row.x_st;
					s.span_end     = row.x_en;
					s.span_index   = row.x_ix;
					s.span_depth   = row.dep;
					s.span_merged  = 1'b0;
					s.last_result  = (l == 0);
					typed_spans.insert(typed_spans.size(), s);
				end
			end
			if (i > 0)
				sender_pause();
			send_trace(t, row.n_typed != BY_MODEL);
		end
		trace_valid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_width(phase_width[p]);
			run_random(RAND_PER_PHASE);
		end

		wait_drained();
		$display("covered %0d traces and %0d span transactions, %0d of them merged spans",
			traces_sent, spans_checked, merged_seen);
		$display("screen width written %0d times: 1, 65535, 0, random, back to reset value",
			widths_done);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
